[hdl/smse_pkg.sv]
// Shared types and constants for the SPI master shift engine.
package smse_pkg;

   // Width of the bit_count field and of the bit counters.
   localparam int CNT_W = 6;
   // Width of the transmit and receive words on the channels.
   localparam int WORD_W = 32;
   localparam int MAX_BITS_DEFAULT = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_TICK  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      REG_ACTIVE_EDGE = 2'd0,
      REG_IDLE_LEVEL  = 2'd1,
      REG_LSB_FIRST   = 2'd2,
      REG_NONE        = 2'd3
   } reg_idx_type;

   // Classified operation handed from front to back.
   typedef enum logic [1:0] {
      OP_START  = 2'd0,
      OP_IGNORE = 2'd1,
      OP_TICK   = 2'd2
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [CNT_W-1:0] count;
      logic             miso;
   } item_ctl_type;

   typedef struct packed {
      logic active_edge;
      logic idle_level;
      logic lsb_first;
   } cfg_type;

endpackage

[hdl/smse_if.sv]
// Channel interfaces for command beats and result beats.
interface smse_req_if;
   logic                            valid;
   logic                            ready;
   logic                            cmd;
   logic [smse_pkg::WORD_W-1:0]     tx_word;
   logic [smse_pkg::CNT_W-1:0]      bit_count;
   logic                            miso;

   modport source (output valid, output cmd, output tx_word, output bit_count,
                   output miso, input ready);
   modport sink   (input valid, input cmd, input tx_word, input bit_count,
                   input miso, output ready);
endinterface

interface smse_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            sclk;
   logic                            mosi;
   logic [smse_pkg::WORD_W-1:0]     rx_word;
   logic                            done_res;
   logic                            busy_res;

   modport source (output valid, output sclk, output mosi, output rx_word,
                   output done_res, output busy_res, input ready);
   modport sink   (input valid, input sclk, input mosi, input rx_word,
                   input done_res, input busy_res, output ready);
endinterface

[hdl/spi_master_shift_engine.sv]
// Top level of the SPI master shift engine: CSR block, front end, queue, back end.
//
//   channel    dir   handshake           carries
//   req_chan   in    valid/ready         cmd, tx_word, bit_count, miso
//   rsp_chan   out   valid/ready         sclk, mosi, rx_word, done_res, busy_res
//   csr (APB)  in    psel/penable        active_edge, idle_level, lsb_first
//
// One command beat per clock sustained while the queue is not full; each beat is written
// into the queue at accept; the back end registers its result once the output is free.
// The two-entry queue lets the front keep taking beats while a result is stalled.
// Reset is synchronous and active high; CSR registers read as zero after reset.
// A start that arrives mid-transfer or with a bad length still yields a result.
module spi_master_shift_engine #(
   parameter int MAX_BITS = smse_pkg::MAX_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   smse_req_if.sink                          req_chan,
   smse_rsp_if.source                        rsp_chan,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [smse_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [smse_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [smse_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);

   smse_pkg::cfg_type      cfg_ff, cfg_in;
   smse_pkg::reg_idx_type  reg_idx;
   logic                   csr_write;

   smse_pkg::item_ctl_type front_ctl;
   logic [MAX_BITS-1:0]    front_data;
   smse_pkg::item_ctl_type q_ctl;
   logic [MAX_BITS-1:0]    q_data;
   logic                   q_full;
   logic                   q_valid;
   logic                   q_pop;
   logic                   q_push;

   assign pready    = 1'b1;
   assign reg_idx   = smse_pkg::reg_idx_type'(paddr[3:2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      prdata = '0;
      unique case (reg_idx)
         smse_pkg::REG_ACTIVE_EDGE: begin
            prdata[0] = cfg_ff.active_edge;
            if (csr_write) cfg_in.active_edge = pwdata[0];
         end
         smse_pkg::REG_IDLE_LEVEL: begin
            prdata[0] = cfg_ff.idle_level;
            if (csr_write) cfg_in.idle_level = pwdata[0];
         end
         smse_pkg::REG_LSB_FIRST: begin
            prdata[0] = cfg_ff.lsb_first;
            if (csr_write) cfg_in.lsb_first = pwdata[0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_chan.ready = !q_full;
   assign q_push         = req_chan.valid && !q_full;

   smse_front #(.MAX_BITS(MAX_BITS)) u_front (
      .cmd       (req_chan.cmd),
      .tx_word   (req_chan.tx_word),
      .bit_count (req_chan.bit_count),
      .miso      (req_chan.miso),
      .lsb_first (cfg_ff.lsb_first),
      .ctl       (front_ctl),
      .tx_load   (front_data)
   );

   smse_queue #(.DATA_W(MAX_BITS)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_ctl  (front_ctl),
      .push_data (front_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_ctl   (q_ctl),
      .pop_data  (q_data)
   );

   smse_back #(.MAX_BITS(MAX_BITS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_valid  (q_valid),
      .q_ctl    (q_ctl),
      .q_data   (q_data),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

[hdl/smse_front.sv]
// Front end: classifies command beats and pre-forms the transmit shift word.
module smse_front #(
   parameter int MAX_BITS = smse_pkg::MAX_BITS_DEFAULT
) (
   input  logic                          cmd,
   input  logic [smse_pkg::WORD_W-1:0]   tx_word,
   input  logic [smse_pkg::CNT_W-1:0]    bit_count,
   input  logic                          miso,
   input  logic                          lsb_first,
   output smse_pkg::item_ctl_type        ctl,
   output logic [MAX_BITS-1:0]           tx_load
);

   localparam int SH_W = $clog2(MAX_BITS + 1);

   logic [63:0]         masked_wide;
   logic [MAX_BITS-1:0] masked;
   logic [MAX_BITS-1:0] reversed;
   logic [SH_W-1:0]     rev_shift;
   logic                count_ok;

   assign count_ok = (bit_count != '0) &&
                     ({1'b0, bit_count} <= (smse_pkg::CNT_W + 1)'(MAX_BITS));

   always_comb begin
      masked_wide = 64'(tx_word) & ~({64{1'b1}} << bit_count);
      masked      = masked_wide[MAX_BITS-1:0];
      for (int i = 0; i < MAX_BITS; i++) begin
         reversed[i] = masked[MAX_BITS-1-i];
      end
      rev_shift = SH_W'(MAX_BITS) - SH_W'(bit_count);
      // MSB first: bit count-1 of the word must go out first from the low end
      tx_load   = lsb_first ? masked : (reversed >> rev_shift);
   end

   always_comb begin
      ctl.count = bit_count;
      ctl.miso  = miso;
      if (cmd == smse_pkg::CMD_TICK) begin
         ctl.op = smse_pkg::OP_TICK;
      end else if (count_ok) begin
         ctl.op = smse_pkg::OP_START;
      end else begin
         ctl.op = smse_pkg::OP_IGNORE;
      end
   end

endmodule

[hdl/smse_queue.sv]
// Two-entry queue between the front and back ends.
module smse_queue #(
   parameter int DATA_W = smse_pkg::MAX_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  smse_pkg::item_ctl_type push_ctl,
   input  logic [DATA_W-1:0]      push_data,
   output logic                   full,
   input  logic                   pop,
   output logic                   not_empty,
   output smse_pkg::item_ctl_type pop_ctl,
   output logic [DATA_W-1:0]      pop_data
);

   localparam int PTR_W = $clog2(smse_pkg::QUEUE_DEPTH);
   localparam int CNT_QW = $clog2(smse_pkg::QUEUE_DEPTH + 1);

   smse_pkg::item_ctl_type ctl_ff  [smse_pkg::QUEUE_DEPTH];
   logic [DATA_W-1:0]      data_ff [smse_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0]      count_ff, count_in;

   assign full      = (count_ff == CNT_QW'(smse_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_ctl   = ctl_ff[rd_ptr_ff];
   assign pop_data  = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(smse_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(smse_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ctl_ff[wr_ptr_ff]  <= push_ctl;
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hdl/smse_back.sv]
// Back end: SPI shift state and the registered result beat.
module smse_back #(
   parameter int MAX_BITS = smse_pkg::MAX_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  smse_pkg::cfg_type      cfg,
   input  logic                   q_valid,
   input  smse_pkg::item_ctl_type q_ctl,
   input  logic [MAX_BITS-1:0]    q_data,
   output logic                   q_pop,
   smse_rsp_if.source             rsp_chan
);

   localparam int SH_W = $clog2(MAX_BITS + 1);

   logic [MAX_BITS-1:0]          tx_shift_ff, tx_shift_in;
   logic [MAX_BITS-1:0]          rx_shift_ff, rx_shift_in;
   logic [smse_pkg::CNT_W-1:0]   bits_left_ff, bits_left_in;
   logic [smse_pkg::CNT_W-1:0]   xfer_len_ff, xfer_len_in;
   logic                         half_phase_ff, half_phase_in;
   logic                         active_ff, active_in;
   logic                         clock_out_ff, clock_out_in;
   logic                         mosi_ff, mosi_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         sclk_ff;
   logic                         mosi_out_ff;
   logic [smse_pkg::WORD_W-1:0]  rx_word_ff, rx_word_in;
   logic                         done_ff, done_in;
   logic                         busy_ff;

   logic [MAX_BITS-1:0]          rx_rev;
   logic [MAX_BITS-1:0]          rx_sel;
   logic [SH_W-1:0]              rx_shamt;

   assign q_pop = q_valid && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      for (int i = 0; i < MAX_BITS; i++) begin
         rx_rev[i] = rx_shift_ff[MAX_BITS-1-i];
      end
      rx_shamt = SH_W'(MAX_BITS) - SH_W'(xfer_len_ff);
      rx_sel   = cfg.lsb_first ? (rx_rev >> rx_shamt) : rx_shift_ff;
   end

   always_comb begin
      tx_shift_in   = tx_shift_ff;
      rx_shift_in   = rx_shift_ff;
      bits_left_in  = bits_left_ff;
      xfer_len_in   = xfer_len_ff;
      half_phase_in = half_phase_ff;
      active_in     = active_ff;
      mosi_in       = mosi_ff;
      clock_out_in  = active_ff ? clock_out_ff : cfg.idle_level;
      rx_word_in    = '0;
      done_in       = 1'b0;
      unique case (q_ctl.op)
         smse_pkg::OP_START: begin
            if (!active_ff) begin
               tx_shift_in   = q_data;
               rx_shift_in   = '0;
               bits_left_in  = q_ctl.count;
               xfer_len_in   = q_ctl.count;
               half_phase_in = 1'b0;
               active_in     = 1'b1;
            end
         end
         smse_pkg::OP_TICK: begin
            if (active_ff) begin
               if (bits_left_ff == '0) begin
                  // closing half: park the clock and hand out the word
                  clock_out_in  = cfg.idle_level;
                  rx_word_in    = smse_pkg::WORD_W'(rx_sel);
                  done_in       = 1'b1;
                  active_in     = 1'b0;
                  half_phase_in = 1'b0;
               end else if (!half_phase_ff) begin
                  clock_out_in  = ~cfg.active_edge;
                  mosi_in       = tx_shift_ff[0];
                  half_phase_in = 1'b1;
               end else begin
                  clock_out_in  = cfg.active_edge;
                  rx_shift_in   = {rx_shift_ff[MAX_BITS-2:0], q_ctl.miso};
                  tx_shift_in   = tx_shift_ff >> 1;
                  bits_left_in  = bits_left_ff - 1'b1;
                  half_phase_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
      rsp_valid_in = q_pop || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_shift_ff   <= '0;
         rx_shift_ff   <= '0;
         bits_left_ff  <= '0;
         xfer_len_ff   <= '0;
         half_phase_ff <= 1'b0;
         active_ff     <= 1'b0;
         clock_out_ff  <= 1'b0;
         mosi_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            tx_shift_ff   <= tx_shift_in;
            rx_shift_ff   <= rx_shift_in;
            bits_left_ff  <= bits_left_in;
            xfer_len_ff   <= xfer_len_in;
            half_phase_ff <= half_phase_in;
            active_ff     <= active_in;
            clock_out_ff  <= clock_out_in;
            mosi_ff       <= mosi_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         sclk_ff     <= clock_out_in;
         mosi_out_ff <= mosi_in;
         rx_word_ff  <= rx_word_in;
         done_ff     <= done_in;
         busy_ff     <= active_in;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.sclk     = sclk_ff;
   assign rsp_chan.mosi     = mosi_out_ff;
   assign rsp_chan.rx_word  = rx_word_ff;
   assign rsp_chan.done_res = done_ff;
   assign rsp_chan.busy_res = busy_ff;

   a_idle_phase: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> !half_phase_ff)
      else $error("half phase set while idle");

   a_bits_bound: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (bits_left_ff <= xfer_len_ff))
      else $error("bits left exceeds transfer length");

   a_start_load: assert property (@(posedge clock) disable iff (reset)
      $rose(active_ff) |-> (bits_left_ff == xfer_len_ff) && (bits_left_ff != '0))
      else $error("transfer started with bad length");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && done_ff) |-> !busy_ff)
      else $error("done beat reports busy");

endmodule
